// File: hw/rtl/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

    localparam int DATA_W  = 64;
    localparam int RAW_W   = 20;
    localparam int CFG_AW  = 2;
    localparam int STATE_W = 5;

    localparam logic [CFG_AW-1:0] REG_TEMP_CALIB  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_PRESS_LOW   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_PRESS_HIGH  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_PRESS_LAST  = 2'd3;

    localparam logic FUNC_TEMP  = 1'b0;
    localparam logic FUNC_PRESS = 1'b1;

    typedef struct packed {
        logic             func;
        logic [RAW_W-1:0] raw_reading;
    } item_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               divide_by_zero;
    } result_t;

    function automatic logic [DATA_W-1:0] sx16(input logic [15:0] w);
        return {{(DATA_W-16){w[15]}}, w};
    endfunction

    function automatic logic [DATA_W-1:0] sar(input logic [DATA_W-1:0] v, input int n);
        return DATA_W'($signed(v) >>> n);
    endfunction

endpackage

// File: hw/rtl/pressure_sensor_compensation.sv
`timescale 1ns / 1ps

// Channel  Signals                               Direction  Moves
// item     item_valid item_ready item            in         func, raw_reading
// result   result_valid result_ready result      out        kind, temp, pressure, flag
// cfg      cfg_valid cfg_ready cfg_index cfg_data in       calibration register write
//
// One shared shift-add multiplier retires one multiplier bit per cycle; the signed
// divide is restoring, one quotient bit per cycle. Temperature: 3 products.
// Pressure: 10 products and one divide. Reset clears calibration, fine
// temperature and control state. A stalled result holds the last step; a new
// item is taken once the sequencer idles.

module pressure_sensor_compensation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  psc_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output psc_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psc_pkg::CFG_AW-1:0]          cfg_index,
    input  logic [psc_pkg::DATA_W-1:0]          cfg_data
);

    localparam logic [psc_pkg::STATE_W-1:0] ST_IDLE = 5'd0;
    localparam logic [psc_pkg::STATE_W-1:0] ST_T0   = 5'd1;
    localparam logic [psc_pkg::STATE_W-1:0] ST_T1   = 5'd2;
    localparam logic [psc_pkg::STATE_W-1:0] ST_T2   = 5'd3;
    localparam logic [psc_pkg::STATE_W-1:0] ST_T3   = 5'd4;
    localparam logic [psc_pkg::STATE_W-1:0] ST_T4   = 5'd5;
    localparam logic [psc_pkg::STATE_W-1:0] ST_T5   = 5'd6;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P0   = 5'd7;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P1   = 5'd8;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P2   = 5'd9;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P3   = 5'd10;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P4   = 5'd11;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P5   = 5'd12;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P6   = 5'd13;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P7   = 5'd14;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P8   = 5'd15;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P9   = 5'd16;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P10  = 5'd17;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P11  = 5'd18;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P12  = 5'd19;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P13  = 5'd20;
    localparam logic [psc_pkg::STATE_W-1:0] ST_P14  = 5'd21;
    localparam logic [psc_pkg::STATE_W-1:0] ST_DZ   = 5'd22;

    localparam int W   = psc_pkg::DATA_W;
    localparam int CW  = $clog2(W);

    logic [47:0]               tcal_reg;
    logic [W-1:0]              plow_reg, phigh_reg;
    logic [15:0]               plast_reg;
    logic [31:0]               fine_reg, fine_next;
    logic [psc_pkg::STATE_W-1:0] st_reg, st_next;
    logic                      busy_reg, busy_next;
    logic                      divmode_reg, divmode_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [W-1:0]              ma_reg, ma_next, mb_reg, mb_next, acc_reg, acc_next;
    logic [W:0]                rem_reg, rem_next;
    logic [W-1:0]              t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next;
    logic                      neg_reg, neg_next;
    logic [psc_pkg::RAW_W-1:0] raw_reg, raw_next;
    logic                      outv_reg, outv_next;
    psc_pkg::result_t          out_reg, out_next;

    logic [W-1:0] t1c, t2c, t3c, p1c, p2c, p3c, p4c, p5c, p6c, p7c, p8c, p9c;
    logic [W-1:0] rawx, qsigned;
    logic [W:0]   rem_sh;
    logic         emit_ok;

    assign t1c = {{(W-16){1'b0}}, tcal_reg[15:0]};
    assign t2c = psc_pkg::sx16(tcal_reg[31:16]);
    assign t3c = psc_pkg::sx16(tcal_reg[47:32]);
    assign p1c = {{(W-16){1'b0}}, plow_reg[15:0]};
    assign p2c = psc_pkg::sx16(plow_reg[31:16]);
    assign p3c = psc_pkg::sx16(plow_reg[47:32]);
    assign p4c = psc_pkg::sx16(plow_reg[63:48]);
    assign p5c = psc_pkg::sx16(phigh_reg[15:0]);
    assign p6c = psc_pkg::sx16(phigh_reg[31:16]);
    assign p7c = psc_pkg::sx16(phigh_reg[47:32]);
    assign p8c = psc_pkg::sx16(phigh_reg[63:48]);
    assign p9c = psc_pkg::sx16(plast_reg);
    assign rawx = {{(W-psc_pkg::RAW_W){1'b0}}, raw_reg};

    assign rem_sh  = {rem_reg[W-1:0], mb_reg[W-1]};
    assign qsigned = neg_reg ? (W'(0) - mb_reg) : mb_reg;
    assign emit_ok = !outv_reg || result_ready;

    assign item_ready   = (st_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = outv_reg;
    assign result       = out_reg;

    always_comb
    begin
        st_next      = st_reg;
        busy_next    = busy_reg;
        divmode_next = divmode_reg;
        cnt_next     = cnt_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        neg_next     = neg_reg;
        raw_next     = raw_reg;
        fine_next    = fine_reg;
        outv_next    = outv_reg && !result_ready;
        out_next     = out_reg;

        if (busy_reg)
        begin
            // advance one bit of the product or quotient
            if (divmode_reg)
            begin
                if (rem_sh >= {1'b0, ma_reg})
                begin
                    rem_next = rem_sh - {1'b0, ma_reg};
                    mb_next  = {mb_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    mb_next  = {mb_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                if (mb_reg[0])
                begin
                    acc_next = acc_reg + ma_reg;
                end
                ma_next = {ma_reg[W-2:0], 1'b0};
                mb_next = {1'b0, mb_reg[W-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W-1))
            begin
                busy_next = 1'b0;
            end
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        raw_next = item.raw_reading;
                        st_next  = item.func ? ST_P0 : ST_T0;
                    end
                end
                ST_T0:
                begin
                    ma_next = {{(W-17){1'b0}}, raw_reg[19:3]} - {t1c[W-2:0], 1'b0};
                    mb_next = t2c;
                end
                ST_T1:
                begin
                    t0_next = psc_pkg::sar(acc_reg, 11);
                    ma_next = {{(W-16){1'b0}}, raw_reg[19:4]} - t1c;
                    mb_next = {{(W-16){1'b0}}, raw_reg[19:4]} - t1c;
                end
                ST_T2:
                begin
                    ma_next = psc_pkg::sar(acc_reg, 12);
                    mb_next = t3c;
                end
                ST_T3:
                begin
                    t0_next = t0_reg + psc_pkg::sar(acc_reg, 14);
                end
                ST_T4:
                begin
                    t1_next = {t0_reg[W-3:0], 2'b00} + t0_reg;
                end
                ST_T5:
                begin
                    if (emit_ok)
                    begin
                        t2_next                    = t1_reg + W'(128);
                        fine_next                  = t0_reg[31:0];
                        outv_next                  = 1'b1;
                        out_next.result_kind       = 1'b0;
                        out_next.temperature_centi = $signed(t2_next[39:8]);
                        out_next.pressure_q24_8    = 32'd0;
                        out_next.divide_by_zero    = 1'b0;
                    end
                end
                ST_P0:
                begin
                    t0_next = {{(W-32){fine_reg[31]}}, fine_reg} - W'(128000);
                    ma_next = t0_next;
                    mb_next = t0_next;
                end
                ST_P1:
                begin
                    t1_next = acc_reg;
                    ma_next = acc_reg;
                    mb_next = p6c;
                end
                ST_P2:
                begin
                    t2_next = acc_reg + {p4c[W-36:0], 35'd0};
                    ma_next = t0_reg;
                    mb_next = p5c;
                end
                ST_P3:
                begin
                    t2_next = t2_reg + {acc_reg[W-18:0], 17'd0};
                    ma_next = t1_reg;
                    mb_next = p3c;
                end
                ST_P4:
                begin
                    t1_next = psc_pkg::sar(acc_reg, 8);
                    ma_next = t0_reg;
                    mb_next = p2c;
                end
                ST_P5:
                begin
                    t1_next = t1_reg + {acc_reg[W-13:0], 12'd0};
                end
                ST_P6:
                begin
                    ma_next = t1_reg + (W'(1) << 47);
                    mb_next = p1c;
                end
                ST_P7:
                begin
                    t1_next = psc_pkg::sar(acc_reg, 33);
                    t0_next = ((W'(1048576) - rawx) << 31) - t2_reg;
                    ma_next = t0_next;
                    mb_next = W'(3125);
                end
                ST_P8:
                begin
                    neg_next = acc_reg[W-1] ^ t1_reg[W-1];
                    mb_next  = acc_reg[W-1] ? (W'(0) - acc_reg) : acc_reg;
                    ma_next  = t1_reg[W-1] ? (W'(0) - t1_reg) : t1_reg;
                    rem_next = '0;
                end
                ST_P9:
                begin
                    t0_next = qsigned;
                    ma_next = psc_pkg::sar(qsigned, 13);
                    mb_next = p9c;
                end
                ST_P10:
                begin
                    ma_next = acc_reg;
                    mb_next = psc_pkg::sar(t0_reg, 13);
                end
                ST_P11:
                begin
                    t1_next = psc_pkg::sar(acc_reg, 25);
                    ma_next = p8c;
                    mb_next = t0_reg;
                end
                ST_P12:
                begin
                    t2_next = t0_reg + t1_reg;
                end
                ST_P13:
                begin
                    t2_next = t2_reg + psc_pkg::sar(acc_reg, 19);
                end
                ST_P14:
                begin
                    if (emit_ok)
                    begin
                        t1_next                    = psc_pkg::sar(t2_reg, 8)
                                                     + {p7c[W-5:0], 4'd0};
                        outv_next                  = 1'b1;
                        out_next.result_kind       = 1'b1;
                        out_next.temperature_centi = 32'sd0;
                        out_next.pressure_q24_8    = t1_next[31:0];
                        out_next.divide_by_zero    = 1'b0;
                    end
                end
                ST_DZ:
                begin
                    if (emit_ok)
                    begin
                        outv_next                  = 1'b1;
                        out_next.result_kind       = 1'b1;
                        out_next.temperature_centi = 32'sd0;
                        out_next.pressure_q24_8    = 32'd0;
                        out_next.divide_by_zero    = 1'b1;
                    end
                end
                default:
                begin
                    st_next = ST_IDLE;
                end
            endcase

            // sequence: start a unit, or step, or finish
            case (st_reg)
                ST_T0, ST_T1, ST_T2, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
                ST_P6, ST_P7, ST_P9, ST_P10, ST_P11:
                begin
                    busy_next    = 1'b1;
                    divmode_next = 1'b0;
                    acc_next     = '0;
                    cnt_next     = '0;
                    st_next      = st_reg + 1'b1;
                    if (st_reg == ST_P7 && t1_next == '0)
                    begin
                        busy_next = 1'b0;
                        st_next   = ST_DZ;
                    end
                end
                ST_P8:
                begin
                    busy_next    = 1'b1;
                    divmode_next = 1'b1;
                    cnt_next     = '0;
                    st_next      = ST_P9;
                end
                ST_T3, ST_T4, ST_P5, ST_P12:
                begin
                    st_next = st_reg + 1'b1;
                end
                ST_P13:
                begin
                    st_next = ST_P14;
                end
                ST_T5, ST_P14, ST_DZ:
                begin
                    if (emit_ok)
                    begin
                        st_next = ST_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            busy_reg    <= 1'b0;
            divmode_reg <= 1'b0;
            cnt_reg     <= '0;
            outv_reg    <= 1'b0;
            fine_reg    <= '0;
            tcal_reg    <= '0;
            plow_reg    <= '0;
            phigh_reg   <= '0;
            plast_reg   <= '0;
        end
        else
        begin
            st_reg      <= st_next;
            busy_reg    <= busy_next;
            divmode_reg <= divmode_next;
            cnt_reg     <= cnt_next;
            outv_reg    <= outv_next;
            fine_reg    <= fine_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    psc_pkg::REG_TEMP_CALIB: tcal_reg  <= cfg_data[47:0];
                    psc_pkg::REG_PRESS_LOW:  plow_reg  <= cfg_data;
                    psc_pkg::REG_PRESS_HIGH: phigh_reg <= cfg_data;
                    psc_pkg::REG_PRESS_LAST: plast_reg <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        neg_reg <= neg_next;
        raw_reg <= raw_next;
        out_reg <= out_next;
    end

endmodule
